FILE: hdl/tql_pkg.sv
`default_nettype none

package tql_pkg;

	localparam int FIELD_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int ACT_W    = 2;
	localparam int STATE_W  = 13;
	localparam int ACTIONS  = 3;
	localparam int VEL_BINS = 3;
	localparam int ONE_Q8   = 256;

	localparam logic signed [FIELD_W-1:0] VEL_HI = 16'sd2048;
	localparam logic signed [FIELD_W-1:0] VEL_LO = -16'sd2048;

	// request kinds
	localparam logic REQ_FRAME    = 1'b0;
	localparam logic REQ_TERMINAL = 1'b1;

	// actions
	localparam logic [ACT_W-1:0] ACT_UP   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_STAY = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DOWN = 2'd2;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_PROB = 2'd2;

	localparam logic [FIELD_W-1:0] LEARN_RATE_RST   = 16'd13107;
	localparam logic [FIELD_W-1:0] DISCOUNT_RST     = 16'd58982;
	localparam logic [FIELD_W-1:0] EXPLORE_PROB_RST = 16'd32768;

	typedef struct packed {
		logic idle;
		logic clear;
		logic bin;
		logic mul1;
		logic mul2;
		logic upd;
		logic pick;
	} tql_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_free;
	} tql_status_t;

endpackage

`default_nettype wire

FILE: hdl/tql_in_if.sv
`default_nettype none

interface tql_in_if import tql_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic signed [FIELD_W-1:0] ball_x;
	logic signed [FIELD_W-1:0] ball_y;
	logic signed [FIELD_W-1:0] ball_vx;
	logic signed [FIELD_W-1:0] ball_vy;
	logic signed [FIELD_W-1:0] own_paddle_y;
	logic signed [FIELD_W-1:0] reward;
	logic [FIELD_W-1:0]        rand_explore;
	logic [FIELD_W-1:0]        rand_pick;

	modport source (
		output valid, req_type, ball_x, ball_y, ball_vx, ball_vy, own_paddle_y,
		output reward, rand_explore, rand_pick,
		input  ready
	);
	modport sink (
		input  valid, req_type, ball_x, ball_y, ball_vx, ball_vy, own_paddle_y,
		input  reward, rand_explore, rand_pick,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/tql_out_if.sv
`default_nettype none

interface tql_out_if import tql_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ACT_W-1:0]   action;
	logic               explored;
	logic [STATE_W-1:0] state_index;

	modport source (output valid, action, explored, state_index, input ready);
	modport sink (input valid, action, explored, state_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/tql_cfg_if.sv
`default_nettype none

interface tql_cfg_if import tql_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FIELD_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tabular_q_learning_agent_core.sv
`default_nettype none

// tabular q-learning agent with epsilon-greedy action choice. each input beat is either a
// frame (observation in signed q3.12, reward in q8.8, two random words) or a terminal
// event. a frame is binned to a state index, the value of the previous state and action is
// updated towards reward + gamma * max q(new state), and an action is chosen: random when
// rand_explore < epsilon, otherwise the argmax with ties split by rand_pick. a terminal
// beat moves the previous value towards the reward and forgets the previous state. every
// input beat gives exactly one result beat. an item passes through the idle state, in
// which the beat is taken, binning and the two table row reads, the dependent multiplies
// (gamma, then alpha), the saturating write back and the action pick, which loads the
// output register. the next beat is taken only once the pick is done and the block is
// idle again, so items are handled one at a time; while the output register holds a
// result the receiver has not taken, the pick waits and no further beat is taken. the
// single-port-write value table and the dependent multiply chain keep items from
// overlapping. after reset the value table is swept to 1.0 one row per cycle,
// X_BINS * Y_BINS * 9 * PADDLE_BINS rows (4608 by default), and no input beat is
// taken until it finishes; configuration writes are taken at any time and should only be
// issued while the block is idle.

module tabular_q_learning_agent_core import tql_pkg::*; #(
	parameter int X_BINS      = 8,
	parameter int Y_BINS      = 8,
	parameter int PADDLE_BINS = 8,
	parameter int VALUE_BITS  = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	tql_cfg_if.sink   cfg,
	tql_in_if.sink    item,
	tql_out_if.source result
);

	// command and status between sequencer and datapath
	tql_cmd_t    cmd;
	tql_status_t st;

	// sequencer: clearing sweep, then one item at a time through bin, multiply, write, pick
	tql_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath: registers, binning, value table, update arithmetic, result register
	tql_dp #(
		.X_BINS      (X_BINS),
		.Y_BINS      (Y_BINS),
		.PADDLE_BINS (PADDLE_BINS),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.st     (st),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

endmodule

`default_nettype wire

FILE: hdl/tql_ctrl.sv
`default_nettype none

module tql_ctrl import tql_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire tql_status_t st,
	output tql_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_BIN,
		S_MUL1,
		S_MUL2,
		S_UPD,
		S_PICK
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (st.clear_done) state_q <= S_IDLE;
				S_IDLE:  if (item_valid) state_q <= S_BIN;
				S_BIN:   state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_UPD;
				S_UPD:   state_q <= S_PICK;
				S_PICK:  if (st.out_free) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.clear = (state_q == S_CLEAR);
		cmd.idle  = (state_q == S_IDLE);
		cmd.bin   = (state_q == S_BIN);
		cmd.mul1  = (state_q == S_MUL1);
		cmd.mul2  = (state_q == S_MUL2);
		cmd.upd   = (state_q == S_UPD);
		cmd.pick  = (state_q == S_PICK);
	end

endmodule

`default_nettype wire

FILE: hdl/tql_dp.sv
`default_nettype none

module tql_dp import tql_pkg::*; #(
	parameter int X_BINS      = 8,
	parameter int Y_BINS      = 8,
	parameter int PADDLE_BINS = 8,
	parameter int VALUE_BITS  = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tql_cmd_t cmd,
	output tql_status_t   st,
	tql_in_if.sink        item,
	tql_out_if.source     result,
	tql_cfg_if.sink       cfg
);

	localparam int STATES = X_BINS * Y_BINS * VEL_BINS * VEL_BINS * PADDLE_BINS;
	localparam int IDX_W  = $clog2(STATES);
	localparam int VB     = VALUE_BITS;
	localparam int RW     = ACTIONS * VB;
	localparam int P1W    = VB + 17;
	localparam int DW     = ((VB > FIELD_W) ? VB : FIELD_W) + 3;
	localparam int P2W    = DW + 17;
	localparam int SW     = DW + 2;

	localparam logic signed [P1W-1:0] RND1 = P1W'(32768);
	localparam logic signed [P2W-1:0] RND2 = P2W'(32768);
	localparam logic signed [SW-1:0]  QMAX = SW'((64'sd1 <<< (VB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0]  QMIN = -QMAX - SW'(1);
	localparam logic [VB-1:0]         Q_ONE = VB'(ONE_Q8);
	localparam logic [RW-1:0]         ROW_INIT = {ACTIONS{Q_ONE}};

	function automatic logic [3:0] pos_bin(input logic signed [FIELD_W-1:0] p,
		input int unsigned nb);
		logic [7:0]  top;
		logic [19:0] prod;
		logic [7:0]  b;
		top  = 8'(nb - 1);
		prod = 20'(p[FIELD_W-2:0]) * 20'(top);
		b    = prod[19:12];
		if (p[FIELD_W-1])
			pos_bin = 4'd0;
		else if (b > top)
			pos_bin = top[3:0];
		else
			pos_bin = b[3:0];
	endfunction

	function automatic logic [1:0] vel_bin(input logic signed [FIELD_W-1:0] v);
		if (v > VEL_HI)
			vel_bin = 2'd2;
		else if (v < VEL_LO)
			vel_bin = 2'd0;
		else
			vel_bin = 2'd1;
	endfunction

	// base-4 digit sums, since 4 is 1 mod 3
	function automatic logic [1:0] mod3(input logic [FIELD_W-1:0] x);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < FIELD_W / 2; i++)
			s = s + 5'(x[2*i +: 2]);
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6)
			t = t - 3'd6;
		else if (t >= 3'd3)
			t = t - 3'd3;
		mod3 = t[1:0];
	endfunction

	function automatic logic signed [VB-1:0] elem(input logic [RW-1:0] row,
		input logic [ACT_W-1:0] a);
		elem = '0;
		for (int i = 0; i < ACTIONS; i++)
			if (ACT_W'(i) == a) elem = row[i*VB +: VB];
	endfunction

	function automatic logic [RW-1:0] set_elem(input logic [RW-1:0] row,
		input logic [ACT_W-1:0] a, input logic [VB-1:0] v);
		set_elem = row;
		for (int i = 0; i < ACTIONS; i++)
			if (ACT_W'(i) == a) set_elem[i*VB +: VB] = v;
	endfunction

	// configuration
	logic [FIELD_W-1:0] alpha_q, gamma_q, eps_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= LEARN_RATE_RST;
			gamma_q <= DISCOUNT_RST;
			eps_q   <= EXPLORE_PROB_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_LEARN_RATE:   alpha_q <= cfg.data;
				REG_DISCOUNT:     gamma_q <= cfg.data;
				REG_EXPLORE_PROB: eps_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// input beat capture
	logic                      req_q;
	logic signed [FIELD_W-1:0] x_q, y_q, vx_q, vy_q, py_q, reward_q;
	logic [FIELD_W-1:0]        rexp_q, rpick_q;

	assign item.ready = cmd.idle;

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			req_q    <= item.req_type;
			x_q      <= item.ball_x;
			y_q      <= item.ball_y;
			vx_q     <= item.ball_vx;
			vy_q     <= item.ball_vy;
			py_q     <= item.own_paddle_y;
			reward_q <= item.reward;
			rexp_q   <= item.rand_explore;
			rpick_q  <= item.rand_pick;
		end
	end

	// binning
	logic [3:0]       bx, by, bpy;
	logic [1:0]       bvx, bvy;
	logic [IDX_W-1:0] idx_c;

	always_comb begin
		bx    = pos_bin(x_q, X_BINS);
		by    = pos_bin(y_q, Y_BINS);
		bpy   = pos_bin(py_q, PADDLE_BINS);
		bvx   = vel_bin(vx_q);
		bvy   = vel_bin(vy_q);
		idx_c = IDX_W'((((int'(bx) * Y_BINS + int'(by)) * VEL_BINS + int'(bvx)) * VEL_BINS
			+ int'(bvy)) * PADDLE_BINS + int'(bpy));
	end

	// previous state and clearing counter
	logic [IDX_W-1:0] prev_idx_q, clr_q, idx_q;
	logic [ACT_W-1:0] prev_act_q;
	logic             prev_valid_q;

	assign st.clear_done = (clr_q == IDX_W'(STATES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear && !st.clear_done) begin
			clr_q <= clr_q + IDX_W'(1);
		end
	end

	// value table
	logic [RW-1:0]    mem [STATES];
	logic [RW-1:0]    row_new_q, row_prev_q, row_pick_q, row_upd;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [RW-1:0]    mem_wd;

	assign mem_we = cmd.clear || (cmd.upd && prev_valid_q);
	assign mem_wa = cmd.clear ? clr_q : prev_idx_q;
	assign mem_wd = cmd.clear ? ROW_INIT : row_upd;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (cmd.bin) begin
			row_new_q  <= mem[idx_c];
			row_prev_q <= mem[prev_idx_q];
		end
	end

	// update arithmetic
	logic signed [VB-1:0]  v0, v1, v2, mx, old_q, new_v;
	logic signed [P1W-1:0] prod1_q, r1;
	logic signed [DW-1:0]  target, diff;
	logic signed [P2W-1:0] prod2_q, r2;
	logic signed [SW-1:0]  sum;

	always_comb begin
		v0 = row_new_q[0 +: VB];
		v1 = row_new_q[VB +: VB];
		v2 = row_new_q[2*VB +: VB];
		mx = v0;
		if (v1 > mx) mx = v1;
		if (v2 > mx) mx = v2;

		r1     = (prod1_q + RND1) >>> 16;
		target = DW'(reward_q) + ((req_q == REQ_FRAME) ? DW'(r1) : DW'(0));
		diff   = target - DW'(old_q);

		r2  = (prod2_q + RND2) >>> 16;
		sum = SW'(old_q) + SW'(r2);
		if (sum > QMAX)
			new_v = VB'(QMAX);
		else if (sum < QMIN)
			new_v = VB'(QMIN);
		else
			new_v = VB'(sum);
		row_upd = set_elem(row_prev_q, prev_act_q, new_v);
	end

	always_ff @(posedge clk) begin
		if (cmd.bin)
			idx_q <= idx_c;
		if (cmd.mul1) begin
			prod1_q <= P1W'(mx) * P1W'(signed'({1'b0, gamma_q}));
			old_q   <= elem(row_prev_q, prev_act_q);
		end
		if (cmd.mul2)
			prod2_q <= P2W'(diff) * P2W'(signed'({1'b0, alpha_q}));
		// same state twice: argmax sees the fresh value
		if (cmd.upd)
			row_pick_q <= (prev_valid_q && prev_idx_q == idx_q) ? row_upd : row_new_q;
	end

	// action choice
	logic signed [VB-1:0] p0, p1, p2, best;
	logic [ACTIONS-1:0]   eq;
	logic [1:0]           cnt, k, seen, sel, act_c;
	logic                 explore;

	always_comb begin
		p0   = row_pick_q[0 +: VB];
		p1   = row_pick_q[VB +: VB];
		p2   = row_pick_q[2*VB +: VB];
		best = p0;
		if (p1 > best) best = p1;
		if (p2 > best) best = p2;
		eq  = {p2 == best, p1 == best, p0 == best};
		cnt = 2'(eq[0]) + 2'(eq[1]) + 2'(eq[2]);
		case (cnt)
			2'd2:    k = {1'b0, rpick_q[0]};
			2'd3:    k = mod3(rpick_q);
			default: k = 2'd0;
		endcase
		sel  = ACT_UP;
		seen = 2'd0;
		for (int i = 0; i < ACTIONS; i++) begin
			if (eq[i]) begin
				if (seen == k) sel = ACT_W'(i);
				seen = seen + 2'd1;
			end
		end
		explore = (rexp_q < eps_q);
		act_c   = explore ? mod3(rpick_q) : sel;
	end

	// result register and previous-state bookkeeping
	logic               res_valid_q, res_expl_q, finish;
	logic [ACT_W-1:0]   res_act_q;
	logic [STATE_W-1:0] res_idx_q;

	assign st.out_free = !res_valid_q || result.ready;
	assign finish      = cmd.pick && st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			prev_idx_q   <= '0;
			prev_act_q   <= ACT_STAY;
			prev_valid_q <= 1'b0;
		end else begin
			if (finish)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
			if (finish) begin
				if (req_q == REQ_TERMINAL) begin
					prev_valid_q <= 1'b0;
				end else begin
					prev_idx_q   <= idx_q;
					prev_act_q   <= act_c;
					prev_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (req_q == REQ_TERMINAL) begin
				res_act_q  <= ACT_STAY;
				res_expl_q <= 1'b0;
				res_idx_q  <= '0;
			end else begin
				res_act_q  <= act_c;
				res_expl_q <= explore;
				res_idx_q  <= STATE_W'(idx_q);
			end
		end
	end

	assign result.valid       = res_valid_q;
	assign result.action      = res_act_q;
	assign result.explored    = res_expl_q;
	assign result.state_index = res_idx_q;

endmodule

`default_nettype wire
